// ===== rtl/xsid_pkg.sv =====
package xsid_pkg;

  localparam int PosWidth  = 32;
  localparam int MaxLength = 15;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TRUNCATED = 2'd1,
    ST_UNKNOWN   = 2'd2,
    ST_TOO_LONG  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    IMM_NONE  = 3'd0,
    IMM_U8    = 3'd1,
    IMM_S8    = 3'd2,
    IMM_U32   = 3'd3,
    IMM_U64   = 3'd4,
    IMM_REL8  = 3'd5,
    IMM_REL32 = 3'd6
  } imm_kind_e;

  // One decoded record as it leaves the front part. The immediate is raw;
  // the back part turns it into its final value.
  typedef struct packed {
    logic [1:0]    status;
    logic [3:0]    length;
    logic [1:0]    opcode_map;
    logic [7:0]    opcode;
    logic [6:0]    prefix_flags;
    logic [3:0]    reg_index;
    logic [1:0]    rm_form;
    logic [3:0]    rm_index;
    logic [6:0]    index_info;
    logic [31:0]   displacement;
    logic [63:0]   imm_raw;
    imm_kind_e     imm_kind;
    logic [PosWidth-1:0] position;
  } rec_t;

endpackage

// ===== rtl/x86_subset_instruction_decoder.sv =====
// Channel | Signals                                   | Direction
// input   | valid_i, stall_o, code_byte_i, first/last  | byte stream in
// output  | valid_o, stall_i, status_o .. immediate_o  | decoded records out
//
// One byte is taken per cycle while stall_o is low; a record passes through the queue, then the output register.
// Decode state lives in the front part; a two-entry queue feeds the output register.
// Reset clears the decode phase, buffer position and all valid flags.
// Input stalls only when the queue is full, so a stalled output blocks the input
// once three records are held (one in the output register, two in the queue).
module x86_subset_instruction_decoder
  import xsid_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [7:0]  code_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [1:0]  status_o,
  output logic [3:0]  length_o,
  output logic [1:0]  opcode_map_o,
  output logic [7:0]  opcode_o,
  output logic [6:0]  prefix_flags_o,
  output logic [3:0]  reg_index_o,
  output logic [1:0]  rm_form_o,
  output logic [3:0]  rm_index_o,
  output logic [6:0]  index_info_o,
  output logic signed [31:0] displacement_o,
  output logic [63:0] immediate_o
);

  logic accept, rec_valid, q_full, q_valid, q_pop;
  rec_t rec, q_data;

  assign stall_o = q_full;
  assign accept  = valid_i && !q_full;

  xsid_front u_front (
    .clk_i, .rst_ni,
    .valid_i(accept), .code_byte_i, .first_byte_i, .last_byte_i,
    .rec_valid_o(rec_valid), .rec_o(rec)
  );

  xsid_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(rec_valid), .data_i(rec), .full_o(q_full),
    .valid_o(q_valid), .pop_i(q_pop), .data_o(q_data)
  );

  xsid_back u_back (
    .clk_i, .rst_ni,
    .rec_valid_i(q_valid), .rec_i(q_data), .rec_pop_o(q_pop),
    .valid_o, .stall_i, .status_o, .length_o, .opcode_map_o, .opcode_o,
    .prefix_flags_o, .reg_index_o, .rm_form_o, .rm_index_o, .index_info_o,
    .displacement_o, .immediate_o
  );

endmodule

// ===== rtl/xsid_front.sv =====
module xsid_front
  import xsid_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] code_byte_i,
  input  logic       first_byte_i,
  input  logic       last_byte_i,
  output logic       rec_valid_o,
  output rec_t       rec_o
);

  typedef enum logic [2:0] {
    PH_PREFIX, PH_OP2, PH_OP3, PH_MODRM, PH_SIB, PH_DISP, PH_IMM
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [PosWidth-1:0] pos_q, pos_d;
  logic [3:0]          len_q, len_d;
  logic [6:0]          pfx_q, pfx_d;
  logic [7:0]          op_q, op_d;
  logic [1:0]          map_q, map_d;
  logic [1:0]          mod_q, mod_d;
  logic [31:0]         disp_q, disp_d;
  logic [63:0]         imm_q, imm_d;
  logic [3:0]          left_q, left_d;
  logic [2:0]          dsize_q, dsize_d;
  logic [3:0]          isize_q, isize_d;
  imm_kind_e           ikind_q, ikind_d;
  logic [3:0]          reg_q, reg_d, rmr_q, rmr_d;
  logic [1:0]          form_q, form_d;
  logic [6:0]          idx_q, idx_d;

  // Decoding of one byte against the phase state.
  always_comb begin
    logic [PosWidth-1:0] pos;
    logic [3:0]  len, dsz, isz, left, shf;
    logic [6:0]  pfx;
    logic [7:0]  op;
    logic [1:0]  map, form, md;
    logic [31:0] disp;
    logic [63:0] imm;
    logic [3:0]  rg, rmr;
    logic [6:0]  idx;
    imm_kind_e   kind;
    phase_e      ph;
    logic        done, unk, setimm, needm, rb, rr, rx, rw;
    logic [7:0]  b;
    pos = pos_q; len = len_q; pfx = pfx_q; op = op_q; map = map_q; md = mod_q;
    disp = disp_q; imm = imm_q; left = left_q; dsz = {1'b0, dsize_q};
    isz = isize_q; kind = ikind_q; rg = reg_q; rmr = rmr_q; form = form_q;
    idx = idx_q; ph = phase_q; shf = '0;
    done = 1'b0; unk = 1'b0; setimm = 1'b0; needm = 1'b0;
    b = code_byte_i;
    if (first_byte_i) begin
      pos = '0; len = '0; pfx = '0; op = '0; map = '0; md = '0; disp = '0;
      imm = '0; left = '0; dsz = '0; isz = '0; kind = IMM_NONE; rg = '0;
      rmr = '0; form = '0; idx = '0; ph = PH_PREFIX;
    end
    pos = pos + 1'b1;
    len = len + 1'b1;
    rb = pfx[6]; rr = pfx[4]; rx = pfx[5]; rw = pfx[3];
    case (ph)
      PH_PREFIX: begin
        if (b == 8'h66) pfx[0] = 1'b1;
        else if (b == 8'hF2) pfx[1] = 1'b1;
        else if (b == 8'hF3) pfx[2] = 1'b1;
        else if (b[7:4] == 4'h4) pfx[6:3] = {b[0], b[1], b[2], b[3]};
        else begin
          op = b; map = 2'd0;
          case (b) inside
            8'h55, 8'h5D, 8'hC9, 8'hC3, 8'hCC, 8'h90: done = 1'b1;
            8'hE8, 8'hE9: begin kind = IMM_REL32; setimm = 1'b1; end
            8'hEB, [8'h70:8'h7F]: begin kind = IMM_REL8; setimm = 1'b1; end
            8'hA8: begin kind = IMM_U8; setimm = 1'b1; end
            8'h31, 8'h33, 8'h09, 8'h0B, 8'h39, 8'h3B, 8'h89, 8'h8B, 8'hFF:
              begin kind = IMM_NONE; needm = 1'b1; end
            8'h81: begin kind = IMM_U32; needm = 1'b1; end
            8'h83: begin kind = IMM_S8; needm = 1'b1; end
            8'hC1: begin kind = IMM_U8; needm = 1'b1; end
            8'h0F: ph = PH_OP2;
            [8'hB8:8'hBF]: begin
              rg = {rb, b[2:0]}; kind = rw ? IMM_U64 : IMM_U32; setimm = 1'b1;
            end
            [8'hB0:8'hB7]: begin rg = {rb, b[2:0]}; kind = IMM_U8; setimm = 1'b1; end
            default: unk = 1'b1;
          endcase
        end
      end
      PH_OP2: begin
        op = b; map = 2'd1;
        case (b) inside
          [8'h80:8'h8F]: begin kind = IMM_REL32; setimm = 1'b1; end
          [8'h90:8'h9F], 8'hB6, 8'h10, 8'h11, 8'h28, 8'h2E, 8'h57, 8'h58, 8'h59,
          8'h5C, 8'h5E, 8'h2A, 8'h2C, 8'h6E, 8'h7E:
            begin kind = IMM_NONE; needm = 1'b1; end
          8'h3A: ph = PH_OP3;
          default: unk = 1'b1;
        endcase
      end
      PH_OP3: begin
        op = b; map = 2'd2;
        if (b == 8'h0B) begin kind = IMM_U8; needm = 1'b1; end
        else unk = 1'b1;
      end
      PH_MODRM: begin
        md = b[7:6];
        rg = {rr, b[5:3]};
        if (b[7:6] == 2'd3) begin form = 2'd1; rmr = {rb, b[2:0]}; setimm = 1'b1; end
        else if (b[2:0] == 3'd4) ph = PH_SIB;
        else begin
          if (b[2:0] == 3'd5 && b[7:6] == 2'd0) begin form = 2'd3; dsz = 4'd4; end
          else begin
            form = 2'd2; rmr = {rb, b[2:0]};
            dsz = (b[7:6] == 2'd1) ? 4'd1 : (b[7:6] == 2'd2) ? 4'd4 : 4'd0;
          end
          setimm = 1'b1;
        end
      end
      PH_SIB: begin
        if (b[2:0] == 3'd5 && md == 2'd0) begin form = 2'd3; dsz = 4'd4; end
        else begin form = 2'd2; rmr = {rb, b[2:0]}; end
        if (!(b[5:3] == 3'd4 && !rx)) idx = {1'b1, b[7:6], rx, b[5:3]};
        if (md == 2'd1) dsz = 4'd1;
        else if (md == 2'd2) dsz = 4'd4;
        setimm = 1'b1;
      end
      PH_DISP: begin
        shf = dsz - left;
        disp = disp | ({24'd0, b} << {shf[1:0], 3'd0});
        left = left - 1'b1;
        if (left == 4'd0) begin
          if (isz != 4'd0) begin ph = PH_IMM; left = isz; end
          else done = 1'b1;
        end
      end
      PH_IMM: begin
        shf = isz - left;
        imm = imm | ({56'd0, b} << {shf[2:0], 3'd0});
        left = left - 1'b1;
        if (left == 4'd0) done = 1'b1;
      end
      default: ph = PH_PREFIX;
    endcase
    // Size the immediate, then route to ModRM, displacement, immediate or finish.
    if (setimm || needm) begin
      case (kind)
        IMM_U8, IMM_S8, IMM_REL8: isz = 4'd1;
        IMM_U32, IMM_REL32:       isz = 4'd4;
        IMM_U64:                  isz = 4'd8;
        default:                  isz = 4'd0;
      endcase
    end
    if (needm) ph = PH_MODRM;
    if (setimm) begin
      if (dsz != 4'd0) begin ph = PH_DISP; left = dsz; end
      else if (isz != 4'd0) begin ph = PH_IMM; left = isz; end
      else done = 1'b1;
    end

    rec_o = '0;
    rec_o.length = len; rec_o.opcode_map = map; rec_o.opcode = op;
    rec_o.prefix_flags = pfx; rec_o.position = pos;
    rec_valid_o = valid_i;
    if (done || (last_byte_i && (ph == PH_DISP || ph == PH_IMM))) begin
      rec_o.status = ST_OK;
      rec_o.reg_index = rg; rec_o.rm_form = form; rec_o.rm_index = rmr;
      rec_o.index_info = idx;
      rec_o.imm_kind = kind;
      if (!done && ph == PH_DISP) begin
        rec_o.imm_raw = '0;
        rec_o.displacement = (left != 4'd0) ? 32'd0 :
          (dsz == 4'd1 ? {{24{disp[7]}}, disp[7:0]} : disp);
      end else begin
        rec_o.displacement = (dsz == 4'd1) ? {{24{disp[7]}}, disp[7:0]} : disp;
        rec_o.imm_raw = (!done && left != 4'd0) ? 64'd0 : imm;
      end
    end else if (unk) rec_o.status = ST_UNKNOWN;
    else if (last_byte_i) rec_o.status = ST_TRUNCATED;
    else if (len >= 4'(MaxLength)) rec_o.status = ST_TOO_LONG;
    else rec_valid_o = 1'b0;

    phase_d = ph; pos_d = pos; len_d = len; pfx_d = pfx; op_d = op; map_d = map;
    mod_d = md; disp_d = disp; imm_d = imm; left_d = left; dsize_d = dsz[2:0];
    isize_d = isz; ikind_d = kind; reg_d = rg; rmr_d = rmr; form_d = form;
    idx_d = idx;
    if (rec_valid_o || last_byte_i) begin
      phase_d = PH_PREFIX; len_d = '0; pfx_d = '0; op_d = '0; map_d = '0;
      mod_d = '0; disp_d = '0; imm_d = '0; left_d = '0; dsize_d = '0;
      isize_d = '0; ikind_d = IMM_NONE; reg_d = '0; rmr_d = '0; form_d = '0;
      idx_d = '0;
    end
  end

  // Decode state advances on each accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PREFIX; pos_q <= '0; len_q <= '0; pfx_q <= '0; op_q <= '0;
      map_q <= '0; mod_q <= '0; disp_q <= '0; imm_q <= '0; left_q <= '0;
      dsize_q <= '0; isize_q <= '0; ikind_q <= IMM_NONE; reg_q <= '0;
      rmr_q <= '0; form_q <= '0; idx_q <= '0;
    end else if (valid_i) begin
      phase_q <= phase_d; pos_q <= pos_d; len_q <= len_d; pfx_q <= pfx_d;
      op_q <= op_d; map_q <= map_d; mod_q <= mod_d; disp_q <= disp_d;
      imm_q <= imm_d; left_q <= left_d; dsize_q <= dsize_d; isize_q <= isize_d;
      ikind_q <= ikind_d; reg_q <= reg_d; rmr_q <= rmr_d; form_q <= form_d;
      idx_q <= idx_d;
    end
  end

endmodule

// ===== rtl/xsid_queue.sv =====
module xsid_queue
  import xsid_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t data_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output rec_t data_o
);

  // Two-entry queue of records between decode and result.
  rec_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0; rptr_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ===== rtl/xsid_back.sv =====
module xsid_back
  import xsid_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rec_valid_i,
  input  rec_t        rec_i,
  output logic        rec_pop_o,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [1:0]  status_o,
  output logic [3:0]  length_o,
  output logic [1:0]  opcode_map_o,
  output logic [7:0]  opcode_o,
  output logic [6:0]  prefix_flags_o,
  output logic [3:0]  reg_index_o,
  output logic [1:0]  rm_form_o,
  output logic [3:0]  rm_index_o,
  output logic [6:0]  index_info_o,
  output logic signed [31:0] displacement_o,
  output logic [63:0] immediate_o
);

  logic          load;
  logic [63:0]   imm_d, imm_q;
  logic [PosWidth-1:0] rel, tgt;
  rec_t          r_q;
  logic          valid_q;

  // Final immediate: extension or branch target.
  always_comb begin
    rel = '0;
    tgt = '0;
    imm_d = '0;
    case (rec_i.imm_kind)
      IMM_U8:  imm_d = {56'd0, rec_i.imm_raw[7:0]};
      IMM_S8:  imm_d = {{56{rec_i.imm_raw[7]}}, rec_i.imm_raw[7:0]};
      IMM_U32: imm_d = {32'd0, rec_i.imm_raw[31:0]};
      IMM_U64: imm_d = rec_i.imm_raw;
      IMM_REL8: begin
        rel = PosWidth'({{56{rec_i.imm_raw[7]}}, rec_i.imm_raw[7:0]});
        tgt = rec_i.position + rel;
        imm_d = 64'(tgt);
      end
      IMM_REL32: begin
        rel = PosWidth'({{32{rec_i.imm_raw[31]}}, rec_i.imm_raw[31:0]});
        tgt = rec_i.position + rel;
        imm_d = 64'(tgt);
      end
      default: imm_d = '0;
    endcase
  end

  assign load      = rec_valid_i && (!valid_q || !stall_i);
  assign rec_pop_o = load;

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (!stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      r_q   <= rec_i;
      imm_q <= imm_d;
    end
  end

  assign valid_o        = valid_q;
  assign status_o       = r_q.status;
  assign length_o       = r_q.length;
  assign opcode_map_o   = r_q.opcode_map;
  assign opcode_o       = r_q.opcode;
  assign prefix_flags_o = r_q.prefix_flags;
  assign reg_index_o    = r_q.reg_index;
  assign rm_form_o      = r_q.rm_form;
  assign rm_index_o     = r_q.rm_index;
  assign index_info_o   = r_q.index_info;
  assign displacement_o = r_q.displacement;
  assign immediate_o    = imm_q;

endmodule
